FILE: hw/rtl/rtde_pkg.sv
// package: constants and helper functions for the rtc date to epoch seconds block
`default_nettype none

package rtde_pkg;

	// field widths
	localparam int unsigned ByteW  = 8;
	localparam int unsigned DaysW  = 17;
	localparam int unsigned TodW   = 20;
	localparam int unsigned EpochW = 32;

	// time constants
	localparam logic [EpochW-1:0] Epoch2000   = 32'd946684800;
	localparam logic [DaysW-1:0]  SecsPerDay  = 17'd86400;
	localparam logic [DaysW-1:0]  DaysPerYear = 17'd365;
	localparam logic [TodW-1:0]   SecsPerHour = 20'd3600;
	localparam logic [TodW-1:0]   SecsPerMin  = 20'd60;

	// months
	localparam logic [ByteW-1:0] MonthJan = 8'd1;
	localparam logic [ByteW-1:0] MonthFeb = 8'd2;
	localparam logic [ByteW-1:0] MonthDec = 8'd12;

	// bcd byte to binary, digits above nine taken as they are
	function automatic logic [ByteW-1:0] from_bcd(input logic [ByteW-1:0] b);
		logic [ByteW-1:0] tens;
		logic [ByteW-1:0] units;
		tens  = {4'b0000, b[7:4]};
		units = {4'b0000, b[3:0]};
		return (tens << 3) + (tens << 1) + units;
	endfunction

	// days before the first of a month, month one based
	function automatic logic [8:0] days_before_month(input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtc_date_to_epoch_seconds.sv
// top level: rtc register bytes to unix seconds, two-stage pipeline
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    rtc_seconds .. rtc_year
// out      output     out_valid / out_ready  epoch_seconds, bad_date
// cfg      input      cfg_we                 cfg_wdata (binary_mode)
//
// one word per cycle unless out_ready stalls; out_valid rises as a word enters stage 2.
// stage 1 converts bcd and forms the day count and time of day, stage 2
// does the single days * 86400 multiply and the final add.
// arst_n clears the valid bits and binary_mode; no clearing pass.
// a stalled out_ready holds both stages; in_ready drops only when both are full.
`default_nettype none

module rtc_date_to_epoch_seconds import rtde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ByteW-1:0]  rtc_seconds,
	input  wire logic [ByteW-1:0]  rtc_minutes,
	input  wire logic [ByteW-1:0]  rtc_hours,
	input  wire logic [ByteW-1:0]  rtc_day,
	input  wire logic [ByteW-1:0]  rtc_month,
	input  wire logic [ByteW-1:0]  rtc_year,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [EpochW-1:0]      epoch_seconds,
	output logic                   bad_date
);

	logic binary_mode_q;

	logic vld_s1;
	logic vld_s2;
	logic adv_s1;
	logic adv_s2;

	logic [ByteW-1:0]  sec_b;
	logic [ByteW-1:0]  min_b;
	logic [ByteW-1:0]  hr_b;
	logic [ByteW-1:0]  day_b;
	logic [ByteW-1:0]  mon_b;
	logic [ByteW-1:0]  yy_b;
	logic              bad_c;
	logic [6:0]        leaps_c;
	logic [1:0]        cent_c;
	logic              y400_c;
	logic              leap_yr_c;
	logic [DaysW-1:0]  days_c;
	logic [TodW-1:0]   tod_c;
	logic [EpochW-1:0] tod_ep_c;

	logic [DaysW-1:0]  days_s1;
	logic [EpochW-1:0] tod_ep_s1;
	logic              bad_s1;

	logic [2*DaysW-1:0] day_secs_c;
	logic [EpochW-1:0]  total_c;

	logic [EpochW-1:0] epoch_s2;
	logic              bad_s2;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q <= 1'b0;
		end else if (cfg_we) begin
			binary_mode_q <= cfg_wdata;
		end
	end

	// pipeline flow control
	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// bcd conversion
	always_comb begin
		if (binary_mode_q) begin
			sec_b = rtc_seconds;
			min_b = rtc_minutes;
			hr_b  = rtc_hours;
			day_b = rtc_day;
			mon_b = rtc_month;
			yy_b  = rtc_year;
		end else begin
			sec_b = from_bcd(rtc_seconds);
			min_b = from_bcd(rtc_minutes);
			hr_b  = from_bcd(rtc_hours);
			day_b = from_bcd(rtc_day);
			mon_b = from_bcd(rtc_month);
			yy_b  = from_bcd(rtc_year);
		end
	end

	// day count since 2000-01-01 and time of day
	always_comb begin
		bad_c  = (mon_b < MonthJan) || (mon_b > MonthDec) || (day_b == '0);
		// centuries 2100 and 2200 drop out, 2000 counts as a 400-year leap
		y400_c = (yy_b != '0);
		cent_c = 2'(y400_c) + 2'(yy_b > 8'd100) + 2'(yy_b > 8'd200);
		leaps_c = 7'((9'({1'b0, yy_b}) + 9'd3) >> 2) - 7'(cent_c) + 7'(y400_c);
		leap_yr_c = (yy_b[1:0] == 2'b00) && (yy_b != 8'd100) && (yy_b != 8'd200);
		days_c = (DaysW'(yy_b) * DaysPerYear) + DaysW'(leaps_c)
			+ DaysW'(days_before_month(mon_b[3:0]))
			+ DaysW'(leap_yr_c && (mon_b > MonthFeb))
			+ DaysW'(day_b - 8'd1);
		tod_c = (TodW'(hr_b) * SecsPerHour) + (TodW'(min_b) * SecsPerMin) + TodW'(sec_b);
		tod_ep_c = EpochW'(tod_c) + Epoch2000;
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			days_s1   <= days_c;
			tod_ep_s1 <= tod_ep_c;
			bad_s1    <= bad_c;
		end
	end

	// seconds total, wraps modulo 2^32
	always_comb begin
		day_secs_c = (2*DaysW)'(days_s1) * (2*DaysW)'(SecsPerDay);
		total_c    = day_secs_c[EpochW-1:0] + tod_ep_s1;
	end

	// stage 2 result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			epoch_s2 <= bad_s1 ? '0 : total_c;
			bad_s2   <= bad_s1;
		end
	end

	assign out_valid     = vld_s2;
	assign epoch_seconds = epoch_s2;
	assign bad_date      = bad_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/rtde_checker.sv
// checker: port-level assertions for the rtc date to epoch seconds block, with bind
`default_nettype none

module rtde_checker import rtde_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [EpochW-1:0] epoch_seconds,
	input wire logic              bad_date
);

	// a flagged word always carries zero seconds
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_date) |-> (epoch_seconds == '0))
		else $error("bad_date word with nonzero epoch_seconds");

	// with the result stage empty the block must take input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while output stage empty");

	// stalled word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("out_valid dropped while stalled");

	// stalled word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(epoch_seconds) && $stable(bad_date)))
		else $error("output payload changed while stalled");

endmodule

bind rtc_date_to_epoch_seconds rtde_checker u_rtde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.epoch_seconds (epoch_seconds),
	.bad_date      (bad_date)
);

`default_nettype wire
